/* src/sam_pkg.sv */
// Shared types, constants and helper functions of the sprite affine matrix block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sam_pkg;

  localparam int CORDIC_STAGES_DEF = 18;
  localparam int MAX_STAGES        = 24;

  // CORDIC datapath width for x, y and z (Q30 with headroom).
  localparam int CW     = 33;
  localparam int ATAN_W = 30;
  // Width of the unreduced angle in Q30.
  localparam int TW     = 36;

  localparam logic signed [CW-1:0] CORDIC_K    = 33'sd652032874;
  localparam logic signed [CW-1:0] PI_Q30      = 33'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [TW-1:0] PI_WIDE     = 36'sd3373259426;
  localparam logic signed [TW-1:0] TWO_PI_WIDE = 36'sd6746518852;

  // Sprite kinds.
  localparam logic [1:0] KIND_COMPOSITE = 2'd0;
  localparam logic [1:0] KIND_IMAGE     = 2'd1;
  localparam logic [1:0] KIND_FONT      = 2'd2;

  localparam logic signed [25:0] ONE_Q10   = 26'sd1024;
  localparam logic signed [28:0] LIN_MAX   = 29'sd33554431;
  localparam logic signed [28:0] LIN_MIN   = -29'sd33554432;
  localparam logic signed [25:0] TRN_MAX   = 26'sd8388608;
  localparam logic signed [25:0] TRN_MIN   = -26'sd8388608;
  localparam logic signed [63:0] HALF_Q46  = 64'sh0000_0008_0000_0000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } cordic_t;

  typedef struct packed {
    logic               ident;
    logic signed [24:0] sx;
    logic signed [24:0] sy;
    logic signed [23:0] kx;
    logic signed [23:0] ky;
    logic signed [24:0] tx;
    logic signed [24:0] ty;
  } sam_pay_t;

  function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
    logic [ATAN_W-1:0] r;
    case (idx)
      5'd0:    r = 30'h3243F6A8;
      5'd1:    r = 30'h1DAC6705;
      5'd2:    r = 30'h0FADBAFC;
      5'd3:    r = 30'h07F56EA6;
      5'd4:    r = 30'h03FEAB76;
      5'd5:    r = 30'h01FFD55B;
      5'd6:    r = 30'h00FFFAAA;
      5'd7:    r = 30'h007FFF55;
      5'd8:    r = 30'h003FFFEA;
      5'd9:    r = 30'h001FFFFD;
      5'd10:   r = 30'h000FFFFF;
      5'd11:   r = 30'h0007FFFF;
      5'd12:   r = 30'h0003FFFF;
      5'd13:   r = 30'h0001FFFF;
      5'd14:   r = 30'h0000FFFF;
      5'd15:   r = 30'h00007FFF;
      5'd16:   r = 30'h00003FFF;
      5'd17:   r = 30'h00001FFF;
      5'd18:   r = 30'h00000FFF;
      5'd19:   r = 30'h000007FF;
      5'd20:   r = 30'h000003FF;
      5'd21:   r = 30'h000001FF;
      5'd22:   r = 30'h000000FF;
      5'd23:   r = 30'h0000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Truncates a value that already carries the half toward zero at 2^-36 and saturates.
  function automatic logic signed [25:0] quant_lin(input logic signed [63:0] s);
    logic signed [27:0] sh;
    logic signed [28:0] q;
    logic signed [28:0] r;
    sh = s[63:36];
    q  = 29'(sh) + (((s[63] == 1'b1) && (s[35:0] != '0)) ? 29'sd1 : 29'sd0);
    if (q > LIN_MAX) begin
      r = LIN_MAX;
    end else if (q < LIN_MIN) begin
      r = LIN_MIN;
    end else begin
      r = q;
    end
    return r[25:0];
  endfunction

  // Converts a Q8 coordinate to units of 1/16: adds half a unit, then truncates toward zero.
  function automatic logic signed [25:0] to_sixteenth(input logic signed [27:0] v);
    logic signed [28:0] s;
    logic signed [25:0] r;
    s = 29'(v) + 29'sd8;
    r = 26'(s >>> 4) + (((s[28] == 1'b1) && (s[3:0] != 4'd0)) ? 26'sd1 : 26'sd0);
    return r;
  endfunction

  function automatic logic signed [24:0] clamp_trn(input logic signed [25:0] v);
    logic signed [25:0] r;
    if (v > TRN_MAX) begin
      r = TRN_MAX;
    end else if (v < TRN_MIN) begin
      r = TRN_MIN;
    end else begin
      r = v;
    end
    return r[24:0];
  endfunction

endpackage

`default_nettype wire

/* src/sam_cordic_cell.sv */
// One rotation-mode CORDIC cell: a single micro-rotation and its pipeline register.
// Depends on sam_pkg for the datapath types and the arctangent table.
`default_nettype none

module sam_cordic_cell
  import sam_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     in_valid,
  input  wire cordic_t  in_cor,
  input  wire sam_pay_t in_pay,
  output logic          out_valid,
  output cordic_t       out_cor,
  output sam_pay_t      out_pay
);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] at;
  cordic_t              cor_nxt;
  logic                 valid_r;
  cordic_t              cor_r;
  sam_pay_t             pay_r;

  always_comb begin
    dx = in_cor.x >>> STAGE;
    dy = in_cor.y >>> STAGE;
    at = $signed({{(CW-ATAN_W){1'b0}}, atan_q30(5'(STAGE))});
    cor_nxt.neg = in_cor.neg;
    if (in_cor.z[CW-1] == 1'b0) begin
      cor_nxt.x = in_cor.x - dy;
      cor_nxt.y = in_cor.y + dx;
      cor_nxt.z = in_cor.z - at;
    end else begin
      cor_nxt.x = in_cor.x + dy;
      cor_nxt.y = in_cor.y - dx;
      cor_nxt.z = in_cor.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cor_r <= cor_nxt;
      pay_r <= in_pay;
    end
  end

  assign out_valid = valid_r;
  assign out_cor   = cor_r;
  assign out_pay   = pay_r;

endmodule

`default_nettype wire

/* src/sam_matrix.sv */
// Product, sum and quantisation pipeline that turns sine, cosine and sprite data into a matrix.
// Depends on sam_pkg; holds the final output register of the block.
`default_nettype none

module sam_matrix
  import sam_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     in_valid,
  input  wire cordic_t  in_cor,
  input  wire sam_pay_t in_pay,
  output logic          out_valid,
  output logic [25:0]   out_a,
  output logic [25:0]   out_b,
  output logic [25:0]   out_c,
  output logic [25:0]   out_d,
  output logic [24:0]   out_tx,
  output logic [24:0]   out_ty
);

  logic [6:0] v_r;
  sam_pay_t   pay1_r, pay2_r, pay3_r, pay4_r, pay5_r, pay6_r;

  // Stage 1: sign correction of the folded angle and split partial products.
  logic signed [CW-1:0] cc, ss;
  logic signed [16:0]   c_hi, c_lo, s_hi, s_lo;
  logic signed [41:0]   puh_r, pul_r, pvh_r, pvl_r, pwh_r, pwl_r, pth_r, ptl_r;

  always_comb begin
    cc   = in_cor.neg ? -in_cor.x : in_cor.x;
    ss   = in_cor.neg ? -in_cor.y : in_cor.y;
    c_hi = cc[32:16];
    c_lo = {1'b0, cc[15:0]};
    s_hi = ss[32:16];
    s_lo = {1'b0, ss[15:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      puh_r  <= in_pay.sx * c_hi;
      pul_r  <= in_pay.sx * c_lo;
      pvh_r  <= in_pay.sx * s_hi;
      pvl_r  <= in_pay.sx * s_lo;
      pwh_r  <= in_pay.sy * c_hi;
      pwl_r  <= in_pay.sy * c_lo;
      pth_r  <= in_pay.sy * s_hi;
      ptl_r  <= in_pay.sy * s_lo;
      pay1_r <= in_pay;
    end
  end

  // Stage 2: recombine the Q46 products.
  logic signed [57:0] u_full, v_full, w_full, t_full;
  logic signed [55:0] u2_r, v2_r, w2_r, t2_r;

  always_comb begin
    u_full = (58'(puh_r) <<< 16) + 58'(pul_r);
    v_full = (58'(pvh_r) <<< 16) + 58'(pvl_r);
    w_full = (58'(pwh_r) <<< 16) + 58'(pwl_r);
    t_full = (58'(pth_r) <<< 16) + 58'(ptl_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u2_r   <= u_full[55:0];
      v2_r   <= v_full[55:0];
      w2_r   <= w_full[55:0];
      t2_r   <= t_full[55:0];
      pay2_r <= pay1_r;
    end
  end

  // Stage 3: shear partial products on the Q30 values.
  logic signed [39:0] u30, v30, w30, t30;
  logic signed [20:0] u_lo, v_lo, w_lo, t_lo;
  logic signed [19:0] u_hi, v_hi, w_hi, t_hi;
  logic signed [44:0] ktl_r, kwl_r, kul_r, kvl_r, kth_r, kwh_r, kuh_r, kvh_r;
  logic signed [55:0] u3_r, v3_r, w3_r, t3_r;

  always_comb begin
    u30  = u2_r[55:16];
    v30  = v2_r[55:16];
    w30  = w2_r[55:16];
    t30  = t2_r[55:16];
    u_lo = {1'b0, u30[19:0]};
    v_lo = {1'b0, v30[19:0]};
    w_lo = {1'b0, w30[19:0]};
    t_lo = {1'b0, t30[19:0]};
    u_hi = u30[39:20];
    v_hi = v30[39:20];
    w_hi = w30[39:20];
    t_hi = t30[39:20];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ktl_r  <= pay2_r.kx * t_lo;
      kth_r  <= pay2_r.kx * t_hi;
      kwl_r  <= pay2_r.kx * w_lo;
      kwh_r  <= pay2_r.kx * w_hi;
      kul_r  <= pay2_r.ky * u_lo;
      kuh_r  <= pay2_r.ky * u_hi;
      kvl_r  <= pay2_r.ky * v_lo;
      kvh_r  <= pay2_r.ky * v_hi;
      u3_r   <= u2_r;
      v3_r   <= v2_r;
      w3_r   <= w2_r;
      t3_r   <= t2_r;
      pay3_r <= pay2_r;
    end
  end

  // Stage 4: recombine the shear products.
  logic signed [63:0] kt4_r, kw4_r, ku4_r, kv4_r;
  logic signed [55:0] u4_r, v4_r, w4_r, t4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      kt4_r  <= (64'(kth_r) <<< 20) + 64'(ktl_r);
      kw4_r  <= (64'(kwh_r) <<< 20) + 64'(kwl_r);
      ku4_r  <= (64'(kuh_r) <<< 20) + 64'(kul_r);
      kv4_r  <= (64'(kvh_r) <<< 20) + 64'(kvl_r);
      u4_r   <= u3_r;
      v4_r   <= v3_r;
      w4_r   <= w3_r;
      t4_r   <= t3_r;
      pay4_r <= pay3_r;
    end
  end

  // Stage 5: matrix entries in Q46.
  logic signed [63:0] ma5_r, mb5_r, mc5_r, md5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ma5_r  <= 64'(u4_r) - kt4_r;
      mb5_r  <= 64'(v4_r) + kw4_r;
      mc5_r  <= ku4_r - 64'(t4_r);
      md5_r  <= kv4_r + 64'(w4_r);
      pay5_r <= pay4_r;
    end
  end

  // Stage 6: add one half before truncation.
  logic signed [63:0] ma6_r, mb6_r, mc6_r, md6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ma6_r  <= ma5_r + HALF_Q46;
      mb6_r  <= mb5_r + HALF_Q46;
      mc6_r  <= mc5_r + HALF_Q46;
      md6_r  <= md5_r + HALF_Q46;
      pay6_r <= pay5_r;
    end
  end

  // Stage 7: truncation, saturation and the identity case into the output register.
  logic signed [25:0] a_r, b_r, c_r, d_r;
  logic signed [24:0] tx_r, ty_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (pay6_r.ident) begin
        a_r  <= ONE_Q10;
        b_r  <= '0;
        c_r  <= '0;
        d_r  <= ONE_Q10;
        tx_r <= '0;
        ty_r <= '0;
      end else begin
        a_r  <= quant_lin(ma6_r);
        b_r  <= quant_lin(mb6_r);
        c_r  <= quant_lin(mc6_r);
        d_r  <= quant_lin(md6_r);
        tx_r <= pay6_r.tx;
        ty_r <= pay6_r.ty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  assign out_valid = v_r[6];
  assign out_a     = a_r;
  assign out_b     = b_r;
  assign out_c     = c_r;
  assign out_d     = d_r;
  assign out_tx    = tx_r;
  assign out_ty    = ty_r;

endmodule

`default_nettype wire

/* src/sprite_affine_matrix.sv */
// Sprite affine matrix block: one 2x3 matrix for every sprite transaction.
// Depends on sam_pkg, sam_cordic_cell and sam_matrix.
//
// The block takes one sprite transaction per clock while in_stall is low and
// returns its matrix through the input register, the wrapped-angle register,
// the fold register, the row of CORDIC cells, one micro-rotation per cell, and
// the split multiplication, summing and rounding stages of sam_matrix. The
// whole pipeline advances together, so it holds only while a finished result
// waits at the output and out_stall is high.
`default_nettype none

module sprite_affine_matrix
  import sam_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_sprite_kind,
  input  wire logic               in_force_transform,
  input  wire logic signed [27:0] in_center_x,
  input  wire logic signed [27:0] in_center_y,
  input  wire logic signed [23:0] in_scale_x,
  input  wire logic signed [23:0] in_scale_y,
  input  wire logic signed [23:0] in_shear_x,
  input  wire logic signed [23:0] in_shear_y,
  input  wire logic signed [19:0] in_angle,
  input  wire logic               in_mirror_x,
  input  wire logic               in_mirror_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [25:0]      out_mat_a,
  output logic signed [25:0]      out_mat_b,
  output logic signed [25:0]      out_mat_c,
  output logic signed [25:0]      out_mat_d,
  output logic signed [24:0]      out_mat_tx,
  output logic signed [24:0]      out_mat_ty
);

  logic en;

  // Input register.
  logic               v0_r;
  logic [1:0]         kind0_r;
  logic               force0_r, mx0_r, my0_r;
  logic signed [27:0] cx0_r, cy0_r;
  logic signed [23:0] sx0_r, sy0_r, kx0_r, ky0_r;
  logic signed [19:0] ang0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      kind0_r  <= in_sprite_kind;
      force0_r <= in_force_transform;
      cx0_r    <= in_center_x;
      cy0_r    <= in_center_y;
      sx0_r    <= in_scale_x;
      sy0_r    <= in_scale_y;
      kx0_r    <= in_shear_x;
      ky0_r    <= in_shear_y;
      ang0_r   <= in_angle;
      mx0_r    <= in_mirror_x;
      my0_r    <= in_mirror_y;
    end
  end

  // Negated angle in Q30, wrapped into [-pi, pi], and the sprite payload.
  logic signed [TW-1:0] theta;
  logic signed [TW-1:0] theta_w;
  logic signed [25:0]   tq_x, tq_y;
  sam_pay_t             pay1_nxt;
  logic                 v1_r;
  logic signed [CW-1:0] z1_r;
  sam_pay_t             pay1_r;

  always_comb begin
    theta = -(TW'(ang0_r) <<< 14);
    if (theta > PI_WIDE) begin
      theta_w = theta - TWO_PI_WIDE;
    end else if (theta < -PI_WIDE) begin
      theta_w = theta + TWO_PI_WIDE;
    end else begin
      theta_w = theta;
    end
    tq_x           = to_sixteenth(cx0_r);
    tq_y           = to_sixteenth(cy0_r);
    pay1_nxt.ident = !force0_r && ((kind0_r == KIND_IMAGE) || (kind0_r == KIND_FONT));
    pay1_nxt.sx    = mx0_r ? -25'(sx0_r) : 25'(sx0_r);
    pay1_nxt.sy    = my0_r ? -25'(sy0_r) : 25'(sy0_r);
    pay1_nxt.kx    = kx0_r;
    pay1_nxt.ky    = ky0_r;
    pay1_nxt.tx    = clamp_trn(tq_x);
    pay1_nxt.ty    = clamp_trn(-tq_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z1_r   <= theta_w[CW-1:0];
      pay1_r <= pay1_nxt;
    end
  end

  // Fold into [-pi/2, pi/2] and seed the CORDIC row.
  cordic_t  cor2_nxt;
  cordic_t  cor_q [0:CORDIC_STAGES];
  sam_pay_t pay_q [0:CORDIC_STAGES];
  logic     vld_q [0:CORDIC_STAGES];
  logic     v2_r;
  cordic_t  cor2_r;
  sam_pay_t pay2_r;

  always_comb begin
    cor2_nxt.x = CORDIC_K;
    cor2_nxt.y = '0;
    if (z1_r > HALF_PI_Q30) begin
      cor2_nxt.z   = z1_r - PI_Q30;
      cor2_nxt.neg = 1'b1;
    end else if (z1_r < -HALF_PI_Q30) begin
      cor2_nxt.z   = z1_r + PI_Q30;
      cor2_nxt.neg = 1'b1;
    end else begin
      cor2_nxt.z   = z1_r;
      cor2_nxt.neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cor2_r <= cor2_nxt;
      pay2_r <= pay1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  assign vld_q[0] = v2_r;
  assign cor_q[0] = cor2_r;
  assign pay_q[0] = pay2_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    sam_cordic_cell #(
      .STAGE(g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (vld_q[g]),
      .in_cor   (cor_q[g]),
      .in_pay   (pay_q[g]),
      .out_valid(vld_q[g+1]),
      .out_cor  (cor_q[g+1]),
      .out_pay  (pay_q[g+1])
    );
  end

  sam_matrix u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (vld_q[CORDIC_STAGES]),
    .in_cor   (cor_q[CORDIC_STAGES]),
    .in_pay   (pay_q[CORDIC_STAGES]),
    .out_valid(out_valid),
    .out_a    (out_mat_a),
    .out_b    (out_mat_b),
    .out_c    (out_mat_c),
    .out_d    (out_mat_d),
    .out_tx   (out_mat_tx),
    .out_ty   (out_mat_ty)
  );

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

endmodule

`default_nettype wire

/* test/tb_sprite_affine_matrix.sv */
// Self-checking testbench for sprite_affine_matrix: random and directed sprites
// are sent in, and every returned matrix is compared with a local prediction.
// Depends on sam_pkg and the sprite_affine_matrix RTL only.
`default_nettype none

module tb_sprite_affine_matrix;

  localparam logic [1:0] KIND_OTHER = 2'd3;
  localparam int     ROT_STAGES = sam_pkg::CORDIC_STAGES_DEF;
  localparam int     ROT_LIMIT  = 24;
  localparam longint ROT_GAIN   = 64'sd652032874;
  localparam longint PI_L       = 64'sd3373259426;
  localparam longint HALF_PI_L  = 64'sd1686629713;
  localparam longint TWO_PI_L   = 64'sd6746518852;
  localparam longint HALF_Q46   = 64'sd34359738368;
  localparam longint ONE_Q46    = 64'sd68719476736;
  localparam longint LIN_HI     = 64'sd33554431;
  localparam longint LIN_LO     = -64'sd33554432;
  localparam longint TRN_LIM    = 64'sd8388608;
  localparam int     RANDOM_SPRITES = 1080;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     DRAIN_CYCLES   = 60;

  typedef struct {
    logic [1:0]         kind;
    logic               force_tf;
    logic signed [27:0] cx;
    logic signed [27:0] cy;
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic signed [23:0] kx;
    logic signed [23:0] ky;
    logic signed [19:0] ang;
    logic               mx;
    logic               my;
  } sprite_t;

  typedef struct {
    logic signed [25:0] a;
    logic signed [25:0] b;
    logic signed [25:0] c;
    logic signed [25:0] d;
    logic signed [24:0] tx;
    logic signed [24:0] ty;
  } matrix_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_sprite_kind = '0;
  logic               in_force_transform = 1'b0;
  logic signed [27:0] in_center_x = '0;
  logic signed [27:0] in_center_y = '0;
  logic signed [23:0] in_scale_x = '0;
  logic signed [23:0] in_scale_y = '0;
  logic signed [23:0] in_shear_x = '0;
  logic signed [23:0] in_shear_y = '0;
  logic signed [19:0] in_angle = '0;
  logic               in_mirror_x = 1'b0;
  logic               in_mirror_y = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [25:0] out_mat_a;
  logic signed [25:0] out_mat_b;
  logic signed [25:0] out_mat_c;
  logic signed [25:0] out_mat_d;
  logic signed [24:0] out_mat_tx;
  logic signed [24:0] out_mat_ty;

  longint  arctan_q30 [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  sprite_t     sprites_to_send[$];
  matrix_t     matrices_due[$];
  logic [31:0] cyc = '0;
  logic        in_taken = 1'b0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  wire         quiet = (cyc[8:7] == 2'b00);

  sprite_affine_matrix u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sprite_kind    (in_sprite_kind),
    .in_force_transform(in_force_transform),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .in_scale_x        (in_scale_x),
    .in_scale_y        (in_scale_y),
    .in_shear_x        (in_shear_x),
    .in_shear_y        (in_shear_y),
    .in_angle          (in_angle),
    .in_mirror_x       (in_mirror_x),
    .in_mirror_y       (in_mirror_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mat_a         (out_mat_a),
    .out_mat_b         (out_mat_b),
    .out_mat_c         (out_mat_c),
    .out_mat_d         (out_mat_d),
    .out_mat_tx        (out_mat_tx),
    .out_mat_ty        (out_mat_ty)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cosine and sine of the negated angle, both in Q30.
  function automatic void sincos_of_negated(input logic signed [19:0] ang,
                                            output longint cos_q30,
                                            output longint sin_q30);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     flip;
    int     k;
    int     i;
    z = -longint'(ang) * 16384;
    x = ROT_GAIN;
    y = 0;
    flip = 1'b0;
    for (k = 0; k < 3; k++) begin
      if (z > PI_L) begin
        z -= TWO_PI_L;
      end else if (z < -PI_L) begin
        z += TWO_PI_L;
      end
    end
    if (z > HALF_PI_L) begin
      z -= PI_L;
      flip = 1'b1;
    end else if (z < -HALF_PI_L) begin
      z += PI_L;
      flip = 1'b1;
    end
    for (i = 0; i < ROT_STAGES && i < ROT_LIMIT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= arctan_q30[i];
      end else begin
        x += dx;
        y -= dy;
        z += arctan_q30[i];
      end
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  function automatic longint limit(input longint v, input longint lo, input longint hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic longint lin_entry(input longint m46);
    return limit((m46 + HALF_Q46) / ONE_Q46, LIN_LO, LIN_HI);
  endfunction

  function automatic matrix_t affine_of(input sprite_t s);
    matrix_t m;
    longint  sx;
    longint  sy;
    longint  kx;
    longint  ky;
    longint  co;
    longint  si;
    longint  u;
    longint  v;
    longint  w;
    longint  t;
    longint  r;
    m.a = 26'sd1024;
    m.b = '0;
    m.c = '0;
    m.d = 26'sd1024;
    m.tx = '0;
    m.ty = '0;
    if (s.force_tf || !(s.kind == sam_pkg::KIND_IMAGE || s.kind == sam_pkg::KIND_FONT)) begin
      sx = s.mx ? -longint'(s.sx) : longint'(s.sx);
      sy = s.my ? -longint'(s.sy) : longint'(s.sy);
      kx = s.kx;
      ky = s.ky;
      sincos_of_negated(s.ang, co, si);
      u = sx * co;
      v = sx * si;
      w = sy * co;
      t = sy * si;
      r = lin_entry(u - kx * (t >>> 16));
      m.a = r[25:0];
      r = lin_entry(v + kx * (w >>> 16));
      m.b = r[25:0];
      r = lin_entry(ky * (u >>> 16) - t);
      m.c = r[25:0];
      r = lin_entry(ky * (v >>> 16) + w);
      m.d = r[25:0];
      r = limit((longint'(s.cx) + 8) / 16, -TRN_LIM, TRN_LIM);
      m.tx = r[24:0];
      r = limit(-((longint'(s.cy) + 8) / 16), -TRN_LIM, TRN_LIM);
      m.ty = r[24:0];
    end
    return m;
  endfunction

  function automatic sprite_t sprite_of(input logic [1:0] kind, input bit ftf,
                                        input int cx, input int cy,
                                        input int sx, input int sy,
                                        input int kx, input int ky,
                                        input int ang, input bit mx, input bit my);
    sprite_t s;
    s.kind = kind;
    s.force_tf = ftf;
    s.cx = cx[27:0];
    s.cy = cy[27:0];
    s.sx = sx[23:0];
    s.sy = sy[23:0];
    s.kx = kx[23:0];
    s.ky = ky[23:0];
    s.ang = ang[19:0];
    s.mx = mx;
    s.my = my;
    return s;
  endfunction

  function automatic void add_sprite(input sprite_t s);
    sprites_to_send = {sprites_to_send, s};
  endfunction

  function automatic sprite_t random_sprite();
    sprite_t s;
    int      r;
    s.kind = 2'($urandom_range(0, 3));
    s.force_tf = ($urandom_range(0, 3) == 0);
    s.cx = ($urandom_range(0, 1) == 0) ? 28'($urandom) : 28'($urandom_range(0, 8191) - 4096);
    s.cy = ($urandom_range(0, 1) == 0) ? 28'($urandom) : 28'($urandom_range(0, 8191) - 4096);
    r = $urandom_range(0, 9);
    s.sx = (r < 7) ? 24'($urandom_range(0, 524288) - 262144) : 24'($urandom);
    r = $urandom_range(0, 9);
    s.sy = (r < 7) ? 24'($urandom_range(0, 524288) - 262144) : 24'($urandom);
    r = $urandom_range(0, 9);
    s.kx = (r < 4) ? 24'd0 : (r < 8) ? 24'($urandom_range(0, 131072) - 65536) : 24'($urandom);
    r = $urandom_range(0, 9);
    s.ky = (r < 4) ? 24'd0 : (r < 8) ? 24'($urandom_range(0, 131072) - 65536) : 24'($urandom);
    s.ang = 20'($urandom);
    s.mx = 1'($urandom_range(0, 1));
    s.my = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  task automatic note_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
  endtask

  always @(negedge clk) begin : sender
    sprite_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (sprites_to_send.size() != 0) begin
        nxt = sprites_to_send.pop_front();
        in_sprite_kind <= nxt.kind;
        in_force_transform <= nxt.force_tf;
        in_center_x <= nxt.cx;
        in_center_y <= nxt.cy;
        in_scale_x <= nxt.sx;
        in_scale_y <= nxt.sy;
        in_shear_x <= nxt.kx;
        in_shear_y <= nxt.ky;
        in_angle <= nxt.ang;
        in_mirror_x <= nxt.mx;
        in_mirror_y <= nxt.my;
        in_valid <= 1'b1;
        gap_left = quiet ? 0 : idle_length();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random and, once, holds off for a long stretch so that the pipeline fills up.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && results_seen >= 200) begin
        out_stall <= 1'b1;
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 2) == 0) begin
          stall_left = idle_length();
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    sprite_t seen;
    matrix_t want;
    cyc <= cyc + 1;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      seen.kind = in_sprite_kind;
      seen.force_tf = in_force_transform;
      seen.cx = in_center_x;
      seen.cy = in_center_y;
      seen.sx = in_scale_x;
      seen.sy = in_scale_y;
      seen.kx = in_shear_x;
      seen.ky = in_shear_y;
      seen.ang = in_angle;
      seen.mx = in_mirror_x;
      seen.my = in_mirror_y;
      matrices_due = {matrices_due, affine_of(seen)};
    end
    if (rst_n && out_valid && !out_stall) begin
      if (matrices_due.size() == 0) begin
        note_mismatch("transaction with no sprite outstanding, mat_a", out_mat_a, 0);
      end else begin
        want = matrices_due.pop_front();
        if (out_mat_a !== want.a) note_mismatch("mat_a", out_mat_a, want.a);
        if (out_mat_b !== want.b) note_mismatch("mat_b", out_mat_b, want.b);
        if (out_mat_c !== want.c) note_mismatch("mat_c", out_mat_c, want.c);
        if (out_mat_d !== want.d) note_mismatch("mat_d", out_mat_d, want.d);
        if (out_mat_tx !== want.tx) note_mismatch("mat_tx", out_mat_tx, want.tx);
        if (out_mat_ty !== want.ty) note_mismatch("mat_ty", out_mat_ty, want.ty);
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    int n;
    add_sprite(sprite_of(sam_pkg::KIND_IMAGE, 0, 134217727, -134217728,
                         8388607, -8388608, 8388607, -8388608, 524287, 1, 1));
    add_sprite(sprite_of(sam_pkg::KIND_FONT, 0, -134217728, 134217727,
                         -8388608, 8388607, -8388608, 8388607, -524288, 0, 1));
    add_sprite(sprite_of(sam_pkg::KIND_IMAGE, 1, 4096, -4096,
                         65536, 65536, 0, 0, 0, 0, 0));
    add_sprite(sprite_of(sam_pkg::KIND_FONT, 1, 4096, -4096,
                         65536, 65536, 0, 0, 51472, 0, 0));
    add_sprite(sprite_of(KIND_OTHER, 0, 256, 256,
                         65536, 131072, 0, 0, 102944, 0, 0));
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, 0, 0,
                         0, 0, 0, 0, 0, 0, 0));
    // Angles at the range ends and around the folding points at pi and pi/2, then scale and shear limits.
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, 0, 0,
                         65536, 65536, 0, 0, 524287, 0, 0));
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, 0, 0,
                         65536, 65536, 0, 0, -524288, 0, 0));
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, 0, 0,
                         65536, 65536, 0, 0, 205887, 0, 0));
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, 0, 0,
                         65536, 65536, 0, 0, 205888, 0, 0));
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, 0, 0,
                         65536, 65536, 0, 0, -205888, 0, 0));
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, 0, 0,
                         65536, 65536, 0, 0, 102943, 0, 0));
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, 0, 0,
                         65536, 65536, 0, 0, -102944, 0, 0));
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, 0, 0,
                         -8388608, -8388608, 0, 0, 0, 1, 1));
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, 0, 0,
                         8388607, 8388607, 8388607, -8388608, 51472, 0, 0));
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, 0, 0,
                         -8388608, 8388607, -8388608, 8388607, -154416, 0, 1));
    // Translation at its limits and at the rounding boundaries near zero.
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, 134217727, 134217727,
                         65536, 65536, 0, 0, 0, 0, 0));
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, -134217728, -134217728,
                         65536, 65536, 0, 0, 0, 0, 0));
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, -8, -9,
                         65536, 65536, 0, 0, 0, 0, 0));
    add_sprite(sprite_of(sam_pkg::KIND_COMPOSITE, 0, -24, 7,
                         65536, 65536, 0, 0, 0, 1, 0));
    add_sprite(sprite_of(KIND_OTHER, 1, 8, -23,
                         65536, 65536, 0, 0, 0, 0, 0));
    for (n = 0; n < RANDOM_SPRITES; n++) begin
      add_sprite(random_sprite());
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    while (sprites_to_send.size() != 0 || in_valid) @(posedge clk);
    while (matrices_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(12 * 400000);
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
src/sam_pkg.sv
src/sam_cordic_cell.sv
src/sam_matrix.sv
src/sprite_affine_matrix.sv
test/tb_sprite_affine_matrix.sv
